/* rtl/hvd_pkg.sv */
// Package with constants, step-angle table and helper functions for the distance unit.
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int QW = 36;
   localparam int LAT_W = 31;
   localparam int LON_W = 32;
   localparam int RAD_W = 23;
   localparam int DIST_W = 28;

   localparam logic signed [QW-1:0] Q_ONE = QW'(64'sd1073741824);
   localparam logic signed [QW-1:0] CORDIC_K = QW'(64'sd652032874);
   localparam logic [32:0] PI_Q = 33'd3373259426;
   localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
   localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6378137);
   localparam logic [0:0] ADDR_RADIUS = 1'b0;

   // Ceiling of PI_Q * 2^63 / 1.8e9, so that angle conversion is a multiplication and a shift.
   localparam logic [63:0] PI_RECIP =
      64'(((128'(PI_Q) << 63) + 128'(HALF_TURN) - 128'd1) / 128'(HALF_TURN));

   typedef logic signed [QW-1:0] q_type;

   function automatic q_type step_angle(input int i);
      q_type a;
      unique case (i)
         0: a = QW'(64'sd843314856);
         1: a = QW'(64'sd497837829);
         2: a = QW'(64'sd263043836);
         3: a = QW'(64'sd133525158);
         4: a = QW'(64'sd67021686);
         5: a = QW'(64'sd33543515);
         6: a = QW'(64'sd16775850);
         7: a = QW'(64'sd8388437);
         8: a = QW'(64'sd4194282);
         9: a = QW'(64'sd2097149);
         default: a = (i <= 30) ? (q_type'(1) <<< (30 - i)) : '0;
      endcase
      return a;
   endfunction

   // Reduces a difference of up to two turns into [-180, 180) degrees.
   function automatic logic signed [33:0] wrap_deg(input logic signed [33:0] u);
      logic signed [34:0] r;
      r = 35'(u);
      if (r >= 35'(HALF_TURN)) r = r - 35'(FULL_TURN);
      if (r >= 35'(HALF_TURN)) r = r - 35'(FULL_TURN);
      if (r < -35'(HALF_TURN)) r = r + 35'(FULL_TURN);
      if (r < -35'(HALF_TURN)) r = r + 35'(FULL_TURN);
      return 34'(r);
   endfunction

   function automatic q_type clamp_unit(input q_type v);
      q_type r;
      if (v < 0) r = '0;
      else if (v > Q_ONE) r = Q_ONE;
      else r = v;
      return r;
   endfunction

   typedef struct packed {
      q_type x;
      q_type y;
      q_type z;
   } cv_type;

   // One rotation-mode step; steps past the iteration count leave the vector unchanged.
   function automatic cv_type rot_step(input cv_type v, input int i);
      cv_type o;
      q_type dx, dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (v.z >= 0) begin
         o.x = v.x - dx; o.y = v.y + dy; o.z = v.z - step_angle(i);
      end else begin
         o.x = v.x + dx; o.y = v.y - dy; o.z = v.z + step_angle(i);
      end
      if (i >= CORDIC_STEPS) o = v;
      return o;
   endfunction

   // One vectoring-mode step; steps past the iteration count leave the vector unchanged.
   function automatic cv_type vec_step(input cv_type v, input int i);
      cv_type o;
      q_type dx, dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (v.y > 0) begin
         o.x = v.x + dx; o.y = v.y - dy; o.z = v.z + step_angle(i);
      end else begin
         o.x = v.x - dx; o.y = v.y + dy; o.z = v.z - step_angle(i);
      end
      if (i >= CORDIC_STEPS) o = v;
      return o;
   endfunction

endpackage
`default_nettype wire

/* rtl/haversine_distance_unit.sv */
// Pipelined great-circle distance unit with a radius register.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall first_lat, first_lon, second_lat, second_lon
// rsp       out        rsp_valid/rsp_stall distance
// csr       in         APB write/read      sphere radius at byte address 0
// A request passes 74 register stages before its result reaches rsp: three for angle
// conversion, (CORDIC_STEPS + 1) / 2 for each CORDIC, four for the products, 32 for the
// square roots and three for scaling. One request per cycle while rsp is not stalled.
// Reset clears all valid bits and loads the default radius.
// A stall on rsp with a valid output freezes the whole pipeline; req_stall is high only when the output
// stage is full and stalled.
module haversine_distance_unit (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire signed [hvd_pkg::LAT_W-1:0] req_first_lat,
   input  wire signed [hvd_pkg::LON_W-1:0] req_first_lon,
   input  wire signed [hvd_pkg::LAT_W-1:0] req_second_lat,
   input  wire signed [hvd_pkg::LON_W-1:0] req_second_lon,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [hvd_pkg::DIST_W-1:0]  rsp_distance,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [2:0]                  csr_paddr,
   input  wire  [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import hvd_pkg::*;

   localparam int CS = (CORDIC_STEPS + 1) / 2;
   localparam int SQ = 32;
   localparam int NS = 3 + CS + 4 + SQ + CS + 3;

   logic adv;
   logic [NS-1:0] v_ff;
   logic [RAD_W-1:0] radius_ff;

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_RADIUS) ? 32'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == ADDR_RADIUS) begin
         radius_ff <= csr_pwdata[RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end
   assign rsp_valid = v_ff[NS-1];

   // Stage A: wrap angles.
   logic signed [33:0] la1_ff, la2_ff, dlat_ff, dlon_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         la1_ff  <= wrap_deg(34'(req_first_lat));
         la2_ff  <= wrap_deg(34'(req_second_lat));
         dlat_ff <= wrap_deg(34'(req_first_lat) - 34'(req_second_lat));
         dlon_ff <= wrap_deg(34'(req_first_lon) - 34'(req_second_lon));
      end
   end

   // Stage B: magnitudes, latitude folding and product with the scaled reciprocal.
   logic [31:0] m_in [4];
   logic [63:0] ph_ff [4];
   logic [63:0] pl_ff [4];
   logic n1_ff, n2_ff;
   always_comb begin
      logic signed [33:0] a1, a2;
      a1 = la1_ff[33] ? -la1_ff : la1_ff;
      a2 = la2_ff[33] ? -la2_ff : la2_ff;
      m_in[0] = 32'((a1 > QUARTER_TURN) ? HALF_TURN - a1 : a1);
      m_in[1] = 32'((a2 > QUARTER_TURN) ? HALF_TURN - a2 : a2);
      m_in[2] = 32'(dlat_ff[33] ? -dlat_ff : dlat_ff);
      m_in[3] = 32'(dlon_ff[33] ? -dlon_ff : dlon_ff);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            ph_ff[k] <= 64'(m_in[k]) * 64'(PI_RECIP[63:32]);
            pl_ff[k] <= 64'(m_in[k]) * 64'(PI_RECIP[31:0]);
         end
         n1_ff <= (la1_ff[33] ? -la1_ff : la1_ff) > QUARTER_TURN;
         n2_ff <= (la2_ff[33] ? -la2_ff : la2_ff) > QUARTER_TURN;
      end
   end

   // Stage C: rounded shift into Q2.30 radians; the two differences are halved.
   logic [95:0] rad_sum [4];
   always_comb begin
      for (int k = 0; k < 4; k++) rad_sum[k] = (96'(ph_ff[k]) << 32) + 96'(pl_ff[k]);
   end
   q_type ang_ff [4];
   logic n1c_ff, n2c_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= QW'((rad_sum[0] + (96'(1) << 62)) >> 63);
         ang_ff[1] <= QW'((rad_sum[1] + (96'(1) << 62)) >> 63);
         ang_ff[2] <= QW'((rad_sum[2] + (96'(1) << 63)) >> 64);
         ang_ff[3] <= QW'((rad_sum[3] + (96'(1) << 63)) >> 64);
         n1c_ff <= n1_ff;
         n2c_ff <= n2_ff;
      end
   end

   // Rotation CORDIC, two steps per stage, four lanes.
   cv_type rc_ff [CS+1][4];
   logic [1:0] nr_ff [CS+1];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rc_ff[0][k] = '{x: CORDIC_K, y: '0, z: ang_ff[k]};
      end
      nr_ff[0] = {n2c_ff, n1c_ff};
   end
   for (genvar s = 0; s < CS; s++) begin : g_rot
      cv_type st_ff [4];
      logic [1:0] n_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 4; k++)
               st_ff[k] <= rot_step(rot_step(rc_ff[s][k], 2*s), 2*s+1);
            n_ff <= nr_ff[s];
         end
      end
      always_comb begin
         rc_ff[s+1] = st_ff;
         nr_ff[s+1] = n_ff;
      end
   end

   // Products: sa^2, sb^2, c1*c2 and c1*c2*sb^2.
   q_type c1_ff, c2_ff, sa_ff, sb_ff;
   logic nd_ff;
   q_type s0, s1;
   assign s0 = clamp_unit(rc_ff[CS][2].y);
   assign s1 = clamp_unit(rc_ff[CS][3].y);
   logic [61:0] sa2_ff, sb2_ff, t0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= clamp_unit(rc_ff[CS][0].x);
         c2_ff <= clamp_unit(rc_ff[CS][1].x);
         sa2_ff <= 62'(31'(s0)) * 62'(31'(s0));
         sb2_ff <= 62'(31'(s1)) * 62'(31'(s1));
         nd_ff <= nr_ff[CS][0] ^ nr_ff[CS][1];
      end
   end
   logic [61:0] sa3_ff, sb3_ff;
   logic nd2_ff, nd3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff <= 62'(31'(c1_ff)) * 62'(31'(c2_ff));
         sa3_ff <= sa2_ff; sb3_ff <= sb2_ff; nd2_ff <= nd_ff;
      end
   end
   logic [61:0] t1_ff, sa4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= 62'(t0_ff[61:30]) * 62'(sb3_ff[61:30]);
         sa4_ff <= sa3_ff; nd3_ff <= nd2_ff;
      end
   end
   q_type h_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff <= clamp_unit(nd3_ff ? QW'(sa4_ff[61:30]) - QW'(t1_ff[61:30])
                                   : QW'(sa4_ff[61:30]) + QW'(t1_ff[61:30]));
      end
   end

   // Two floor square roots, one digit per stage.
   typedef struct packed {
      logic [61:0] n;
      logic [61:0] r;
   } sq_type;
   function automatic sq_type sq_step(input sq_type a, input int j);
      sq_type o;
      logic [61:0] b;
      b = 62'(1) << (2 * (SQ - 1 - j));
      o = a;
      if (a.n >= a.r + b) begin
         o.n = a.n - (a.r + b);
         o.r = (a.r >> 1) + b;
      end else begin
         o.r = a.r >> 1;
      end
      return o;
   endfunction
   sq_type sq_ff [SQ+1][2];
   assign sq_ff[0][0] = '{n: 62'(h_ff) << 30, r: '0};
   assign sq_ff[0][1] = '{n: 62'(Q_ONE - h_ff) << 30, r: '0};
   for (genvar j = 0; j < SQ; j++) begin : g_sq
      sq_type st_ff [2];
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[0] <= sq_step(sq_ff[j][0], j);
            st_ff[1] <= sq_step(sq_ff[j][1], j);
         end
      end
      assign sq_ff[j+1] = st_ff;
   end

   // Vectoring CORDIC, two steps per stage.
   cv_type vc_ff [CS+1];
   assign vc_ff[0] = '{x: QW'(sq_ff[SQ][1].r), y: QW'(sq_ff[SQ][0].r), z: '0};
   for (genvar s = 0; s < CS; s++) begin : g_vec
      cv_type st_ff;
      always_ff @(posedge clock) begin
         if (adv) st_ff <= vec_step(vec_step(vc_ff[s], 2*s), 2*s+1);
      end
      assign vc_ff[s+1] = st_ff;
   end

   // Scale by the radius, round and saturate at DIST_MAX.
   logic [35:0] z20_ff;
   logic [63:0] d_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         z20_ff <= (vc_ff[CS].z < 0) ? '0 : 36'(vc_ff[CS].z[30:0]) * 36'd20;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) d_ff <= (64'(z20_ff) * 64'(radius_ff) + (64'(1) << 29)) >> 30;
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_distance <= (d_ff > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_ff);
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("result lost under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall mismatch");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= DIST_MAX)
      else $error("distance out of range");

endmodule
`default_nettype wire
